[hw/rtl/m3inv_pkg.sv]
package m3inv_pkg;

  // element format
  localparam int unsigned ElemW = 32;
  localparam int unsigned FracB = 16;
  localparam int unsigned NumEl = 9;
  localparam int unsigned NumRow = 3;
  localparam int unsigned ThrW = 31;

  // internal widths
  localparam int unsigned ProdW = 2 * ElemW;
  localparam int unsigned CofRawW = ProdW + 1 - FracB;
  localparam int unsigned CofW = (CofRawW < 64) ? CofRawW : 64;
  localparam int unsigned CofHiW = CofW - ElemW;
  localparam int unsigned LoW = 2 * ElemW + 1;
  localparam int unsigned TermW = ElemW + CofW;
  localparam int unsigned DetW = TermW + 2;
  localparam int unsigned NumW =
    ((CofW + 2 * FracB > DetW) ? CofW + 2 * FracB : DetW) + 1;
  localparam int unsigned DenW = DetW + 1;
  localparam int unsigned QuoW = ElemW;
  localparam int unsigned CmpW = DenW + QuoW;

  // queue between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = $clog2(QDepth);

  // element indexes p, q, r, s of each cofactor p*q - r*s
  localparam int CofIdx [NumEl][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  // cofactors used in the expansion along the first row
  localparam int DetIdx [NumRow] = '{0, 3, 6};

  // one classified matrix handed from front to back
  typedef struct packed {
    logic [NumEl-1:0][CofW-1:0] cof;
    logic                       det_neg;
    logic [DetW-1:0]            dmag;
    logic                       singular;
    logic                       clip;
  } m3inv_job_t;

endpackage

[hw/rtl/m3inv_front.sv]
module m3inv_front (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        cfg_we_i,
  input  logic [m3inv_pkg::ThrW-1:0]                  cfg_wdata_i,
  input  logic                                        s_valid_i,
  output logic                                        s_ready_o,
  input  logic [m3inv_pkg::NumEl*m3inv_pkg::ElemW-1:0] s_data_i,
  output logic                                        job_valid_o,
  input  logic                                        job_ready_i,
  output m3inv_pkg::m3inv_job_t                       job_o
);
  import m3inv_pkg::*;

  logic [6:0] v_q;
  logic       en;
  logic [ThrW-1:0] thr_q;

  logic signed [ElemW-1:0] a0_q [NumEl];
  logic signed [ProdW-1:0] pp_q [NumEl];
  logic signed [ProdW-1:0] pm_q [NumEl];
  logic signed [ElemW-1:0] a1_q [NumRow];
  logic signed [CofW-1:0]  cof_d [NumEl];
  logic                    clip_d;
  logic signed [CofW-1:0]  cof2_q [NumEl];
  logic                    clip2_q;
  logic signed [ElemW-1:0] a2_q [NumRow];
  logic signed [LoW-1:0]   plo_q [NumRow];
  logic signed [CofW-1:0]  phi_q [NumRow];
  logic signed [CofW-1:0]  cof3_q [NumEl];
  logic                    clip3_q;
  logic signed [TermW-1:0] term_q [NumRow];
  logic signed [CofW-1:0]  cof4_q [NumEl];
  logic                    clip4_q;
  logic signed [DetW-1:0]  det_q;
  logic signed [CofW-1:0]  cof5_q [NumEl];
  logic                    clip5_q;
  logic [DetW-1:0]         dmag_d;
  logic [ThrW+FracB-1:0]   lim;
  m3inv_job_t              job_q;

  // whole front advances unless the last stage is stuck
  assign en          = ~(v_q[6] & ~job_ready_i);
  assign s_ready_o   = en;
  assign job_valid_o = v_q[6];
  assign job_o       = job_q;

  // zero threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrW'(1);
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[5:0], s_valid_i};
    end
  end

  // cofactor rounding and clipping
  always_comb begin
    logic signed [ProdW:0]     diff;
    logic signed [CofRawW-1:0] raw;
    logic signed [CofRawW-1:0] hi;
    logic                      cl;
    clip_d = 1'b0;
    for (int i = 0; i < NumEl; i++) begin
      diff = (ProdW + 1)'(pp_q[i]) - (ProdW + 1)'(pm_q[i])
             + ((ProdW + 1)'(1) <<< (FracB - 1));
      raw  = diff[ProdW:FracB];
      hi   = raw >>> (CofW - 1);
      cl   = (hi != '0) && (hi != '1);
      cof_d[i] = cl ? {raw[CofRawW-1], {(CofW - 1){~raw[CofRawW-1]}}}
                    : raw[CofW-1:0];
      clip_d = clip_d | cl;
    end
  end

  // singular test against threshold plus half an lsb
  assign lim    = {thr_q, 1'b1, {(FracB - 1){1'b0}}};
  assign dmag_d = det_q[DetW-1] ? DetW'(-det_q) : DetW'(det_q);

  // datapath stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      // capture the matrix
      for (int i = 0; i < NumEl; i++) begin
        a0_q[i] <= $signed(s_data_i[i*ElemW +: ElemW]);
      end
      // cofactor products
      for (int i = 0; i < NumEl; i++) begin
        pp_q[i] <= ProdW'(a0_q[CofIdx[i][0]]) * ProdW'(a0_q[CofIdx[i][1]]);
        pm_q[i] <= ProdW'(a0_q[CofIdx[i][2]]) * ProdW'(a0_q[CofIdx[i][3]]);
      end
      for (int r = 0; r < NumRow; r++) begin
        a1_q[r] <= a0_q[r];
      end
      // cofactors
      for (int i = 0; i < NumEl; i++) begin
        cof2_q[i] <= cof_d[i];
      end
      clip2_q <= clip_d;
      for (int r = 0; r < NumRow; r++) begin
        a2_q[r] <= a1_q[r];
      end
      // split products for the expansion
      for (int r = 0; r < NumRow; r++) begin
        plo_q[r] <= LoW'(a2_q[r])
                    * LoW'($signed({1'b0, cof2_q[DetIdx[r]][ElemW-1:0]}));
        phi_q[r] <= CofW'(a2_q[r])
                    * CofW'($signed(cof2_q[DetIdx[r]][CofW-1:ElemW]));
      end
      cof3_q  <= cof2_q;
      clip3_q <= clip2_q;
      // recombine partial products
      for (int r = 0; r < NumRow; r++) begin
        term_q[r] <= (TermW'(phi_q[r]) <<< ElemW) + TermW'(plo_q[r]);
      end
      cof4_q  <= cof3_q;
      clip4_q <= clip3_q;
      // determinant
      det_q   <= DetW'(term_q[0]) + DetW'(term_q[1]) + DetW'(term_q[2]);
      cof5_q  <= cof4_q;
      clip5_q <= clip4_q;
      // classify
      for (int i = 0; i < NumEl; i++) begin
        job_q.cof[i] <= cof5_q[i];
      end
      job_q.det_neg  <= det_q[DetW-1];
      job_q.dmag     <= dmag_d;
      job_q.singular <= dmag_d < DetW'(lim);
      job_q.clip     <= clip5_q;
    end
  end

endmodule

[hw/rtl/m3inv_queue.sv]
module m3inv_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_valid_i,
  output logic                  wr_ready_o,
  input  m3inv_pkg::m3inv_job_t wr_data_i,
  output logic                  rd_valid_o,
  input  logic                  rd_ready_i,
  output m3inv_pkg::m3inv_job_t rd_data_o
);
  import m3inv_pkg::*;

  m3inv_job_t       mem [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   cnt_q;
  logic             full, empty, push, pop;

  assign full       = cnt_q == (QPtrW + 1)'(QDepth);
  assign empty      = cnt_q == '0;
  assign push       = wr_valid_i & ~full;
  assign pop        = rd_ready_i & ~empty;
  assign wr_ready_o = ~full;
  assign rd_valid_o = ~empty;
  assign rd_data_o  = mem[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      if (push & ~pop)      cnt_q <= cnt_q + (QPtrW + 1)'(1);
      else if (pop & ~push) cnt_q <= cnt_q - (QPtrW + 1)'(1);
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) mem[wr_ptr_q] <= wr_data_i;
  end

endmodule

[hw/rtl/m3inv_back.sv]
module m3inv_back (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        job_valid_i,
  output logic                                        job_ready_o,
  input  m3inv_pkg::m3inv_job_t                       job_i,
  output logic                                        m_valid_o,
  input  logic                                        m_ready_i,
  output logic [m3inv_pkg::NumEl*m3inv_pkg::ElemW-1:0] m_data_o,
  output logic [1:0]                                  m_user_o
);
  import m3inv_pkg::*;

  localparam int unsigned BackN = QuoW + 4;

  typedef struct packed {
    logic [NumEl-1:0] neg;
    logic [NumEl-1:0] ovf;
    logic             sing;
    logic             clip;
    logic [DenW-1:0]  den;
  } side_t;

  logic             en, pop;
  logic [BackN-1:0] v_q;
  logic             m_valid_q;

  m3inv_job_t       job0_q;
  logic [CofW-1:0]  cmag_q [NumEl];
  logic [NumEl-1:0] neg1_q;
  logic [DetW-1:0]  dmag1_q;
  logic             sing1_q, clip1_q;
  logic [NumW-1:0]  num_q [NumEl];
  logic [NumEl-1:0] neg2_q;
  logic [DenW-1:0]  den2_q;
  logic             sing2_q, clip2_q;

  logic [NumW-1:0]  rem_q [QuoW+1][NumEl];
  logic [QuoW-1:0]  quo_q [QuoW+1][NumEl];
  side_t            sd_q  [QuoW+1];
  logic [NumW-1:0]  rem_nx [QuoW][NumEl];
  logic [QuoW-1:0]  quo_nx [QuoW][NumEl];
  logic [NumEl-1:0] ovf_d;

  logic [NumEl*ElemW-1:0] res_d;
  logic [1:0]             user_d;
  logic [NumEl*ElemW-1:0] m_data_q;
  logic [1:0]             m_user_q;

  // back pipeline moves unless the output is held
  assign en          = ~m_valid_q | m_ready_i;
  assign pop         = en & job_valid_i;
  assign job_ready_o = en;
  assign m_valid_o   = m_valid_q;
  assign m_data_o    = m_data_q;
  assign m_user_o    = m_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q       <= '0;
      m_valid_q <= 1'b0;
    end else if (en) begin
      v_q       <= {v_q[BackN-2:0], pop};
      m_valid_q <= v_q[BackN-1];
    end
  end

  // overflow check: quotient of 2^QuoW or more
  always_comb begin
    for (int l = 0; l < NumEl; l++) begin
      ovf_d[l] = CmpW'(num_q[l]) >= (CmpW'(den2_q) << QuoW);
    end
  end

  // one restoring division step per stage, all lanes share the divisor
  always_comb begin
    logic [CmpW-1:0] dsh;
    logic            ge;
    for (int s = 0; s < QuoW; s++) begin
      for (int l = 0; l < NumEl; l++) begin
        dsh = CmpW'(sd_q[s].den) << (QuoW - 1 - s);
        ge  = CmpW'(rem_q[s][l]) >= dsh;
        rem_nx[s][l] = ge ? NumW'(CmpW'(rem_q[s][l]) - dsh) : rem_q[s][l];
        quo_nx[s][l] = quo_q[s][l] | (QuoW'(ge) << (QuoW - 1 - s));
      end
    end
  end

  // rounding already folded in, now saturate and apply sign
  always_comb begin
    logic [QuoW-1:0]  capv, m;
    logic             over;
    logic             any;
    logic [ElemW-1:0] r;
    any = 1'b0;
    for (int l = 0; l < NumEl; l++) begin
      capv = {sd_q[QuoW].neg[l], {(ElemW - 1){~sd_q[QuoW].neg[l]}}};
      over = sd_q[QuoW].ovf[l] | (quo_q[QuoW][l] > capv);
      m    = over ? capv : quo_q[QuoW][l];
      r    = sd_q[QuoW].neg[l] ? ElemW'(-m) : ElemW'(m);
      any  = any | over;
      res_d[l*ElemW +: ElemW] = sd_q[QuoW].sing ? '0 : r;
    end
    user_d[0] = sd_q[QuoW].sing;
    user_d[1] = ~sd_q[QuoW].sing & (sd_q[QuoW].clip | any);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // take one transaction from the queue
      job0_q <= job_i;
      // magnitudes and result signs
      for (int l = 0; l < NumEl; l++) begin
        cmag_q[l] <= job0_q.cof[l][CofW-1] ? CofW'(-job0_q.cof[l]) : job0_q.cof[l];
        neg1_q[l] <= job0_q.cof[l][CofW-1] ^ job0_q.det_neg;
      end
      dmag1_q <= job0_q.dmag;
      sing1_q <= job0_q.singular;
      clip1_q <= job0_q.clip;
      // dividend and divisor for round to nearest
      for (int l = 0; l < NumEl; l++) begin
        num_q[l] <= (NumW'(cmag_q[l]) << (2 * FracB + 1)) + NumW'(dmag1_q);
      end
      den2_q  <= {dmag1_q, 1'b0};
      neg2_q  <= neg1_q;
      sing2_q <= sing1_q;
      clip2_q <= clip1_q;
      // divider entry
      for (int l = 0; l < NumEl; l++) begin
        rem_q[0][l] <= num_q[l];
        quo_q[0][l] <= '0;
      end
      sd_q[0].neg  <= neg2_q;
      sd_q[0].ovf  <= ovf_d;
      sd_q[0].sing <= sing2_q;
      sd_q[0].clip <= clip2_q;
      sd_q[0].den  <= den2_q;
      // divider stages
      for (int s = 0; s < QuoW; s++) begin
        for (int l = 0; l < NumEl; l++) begin
          rem_q[s+1][l] <= rem_nx[s][l];
          quo_q[s+1][l] <= quo_nx[s][l];
        end
        sd_q[s+1] <= sd_q[s];
      end
      // output register
      m_data_q <= res_d;
      m_user_q <= user_d;
    end
  end

endmodule

[hw/rtl/matrix3x3_inverse_top.sv]
// Inverts one 3x3 matrix of signed Q16.16 elements per transaction, at a
// sustained rate of one matrix per clock cycle while the output is not held.
// The front end forms the nine cofactors (rounded to Q33.16), the
// determinant by expansion along the first row and the singular decision
// (rounded determinant magnitude at or below zero_threshold, reset value 1
// lsb). A four-entry queue then feeds the back end, where nine lanes of a
// 32-stage pipelined restoring divider, one quotient bit per stage, produce
// each element of adjugate/determinant rounded to nearest (ties away from
// zero) and saturated to 32 bits. A singular matrix gives all-zero elements
// with singular set and saturated clear. Write the threshold only while no
// transaction is in flight.
module matrix3x3_inverse_top (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        cfg_we_i,
  input  logic [m3inv_pkg::ThrW-1:0]                  cfg_wdata_i,
  input  logic                                        s_axis_tvalid,
  output logic                                        s_axis_tready,
  // a00, a01, a02, a10, a11, a12, a20, a21, a22 (32 bits each)
  input  logic [m3inv_pkg::NumEl*m3inv_pkg::ElemW-1:0] s_axis_tdata,
  output logic                                        m_axis_tvalid,
  input  logic                                        m_axis_tready,
  // r00, r01, r02, r10, r11, r12, r20, r21, r22 (32 bits each)
  output logic [m3inv_pkg::NumEl*m3inv_pkg::ElemW-1:0] m_axis_tdata,
  // singular, saturated
  output logic [1:0]                                  m_axis_tuser
);
  import m3inv_pkg::*;

  logic       f_valid, f_ready, b_valid, b_ready;
  m3inv_job_t f_job, b_job;

  // cofactors, determinant and classification
  m3inv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_data_i    (s_axis_tdata),
    .job_valid_o (f_valid),
    .job_ready_i (f_ready),
    .job_o       (f_job)
  );

  // decoupling queue
  m3inv_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_data_i  (f_job),
    .rd_valid_o (b_valid),
    .rd_ready_i (b_ready),
    .rd_data_o  (b_job)
  );

  // division, saturation and output register
  m3inv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (b_valid),
    .job_ready_o (b_ready),
    .job_i       (b_job),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata),
    .m_user_o    (m_axis_tuser)
  );

endmodule
